@@ rtl/core/tpd_pkg.sv @@
// Shared types and constants for the touch pad debounce, hold and repeat unit.
// Holds the configuration struct, lane result struct and register indexes.
// No dependencies.
package tpd_pkg;

    localparam int MAX_PADS   = 8;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    // Register reset values
    localparam logic [7:0]      RST_ENABLED_INPUTS  = 8'd137;
    localparam logic [MS_W-1:0] RST_PRESS_DEBOUNCE  = 16'd20;
    localparam logic [MS_W-1:0] RST_RELEASE_DEBOUNCE = 16'd50;
    localparam logic [MS_W-1:0] RST_MIN_ACTION      = 16'd30;
    localparam logic [MS_W-1:0] RST_HOLD            = 16'd1000;
    localparam logic [MS_W-1:0] RST_REPEAT_DELAY    = 16'd500;
    localparam logic [MS_W-1:0] RST_REPEAT_RATE     = 16'd150;
    localparam logic [31:0]     RST_HANDLER_MASK    = 32'd0;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLED_INPUTS  = 3'd0,
        REG_PRESS_DEBOUNCE  = 3'd1,
        REG_RELEASE_DEBOUNCE = 3'd2,
        REG_MIN_ACTION      = 3'd3,
        REG_HOLD            = 3'd4,
        REG_REPEAT_DELAY    = 3'd5,
        REG_REPEAT_RATE     = 3'd6,
        REG_HANDLER_MASK    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]      enabled_inputs;
        logic [MS_W-1:0] press_debounce_ms;
        logic [MS_W-1:0] release_debounce_ms;
        logic [MS_W-1:0] min_action_ms;
        logic [MS_W-1:0] hold_ms;
        logic [MS_W-1:0] repeat_delay_ms;
        logic [MS_W-1:0] repeat_rate_ms;
        logic [31:0]     handler_mask;
    } cfg_t;

    // Per-pad handler enables
    typedef struct packed {
        logic press;
        logic release_en;
        logic hold;
        logic repeat_en;
    } hnd_t;

    // What one lane reports for one item
    typedef struct packed {
        logic pressed;
        logic ev_press;
        logic ev_release;
        logic ev_hold;
        logic ev_repeat;
        logic press_edge;
        logic release_edge;
    } lane_res_t;

endpackage

@@ rtl/core/tpd_cfg.sv @@
// Configuration register file for the touch pad unit.
// Depends on tpd_pkg for the register struct, indexes and reset values.
module tpd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output tpd_pkg::cfg_t                    cfg
);
    import tpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_ENABLED_INPUTS:   cfg_next.enabled_inputs      = cfg_wdata[7:0];
                REG_PRESS_DEBOUNCE:   cfg_next.press_debounce_ms   = cfg_wdata[MS_W-1:0];
                REG_RELEASE_DEBOUNCE: cfg_next.release_debounce_ms = cfg_wdata[MS_W-1:0];
                REG_MIN_ACTION:       cfg_next.min_action_ms       = cfg_wdata[MS_W-1:0];
                REG_HOLD:             cfg_next.hold_ms             = cfg_wdata[MS_W-1:0];
                REG_REPEAT_DELAY:     cfg_next.repeat_delay_ms     = cfg_wdata[MS_W-1:0];
                REG_REPEAT_RATE:      cfg_next.repeat_rate_ms      = cfg_wdata[MS_W-1:0];
                REG_HANDLER_MASK:     cfg_next.handler_mask        = cfg_wdata[31:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled_inputs      <= RST_ENABLED_INPUTS;
            cfg_reg.press_debounce_ms   <= RST_PRESS_DEBOUNCE;
            cfg_reg.release_debounce_ms <= RST_RELEASE_DEBOUNCE;
            cfg_reg.min_action_ms       <= RST_MIN_ACTION;
            cfg_reg.hold_ms             <= RST_HOLD;
            cfg_reg.repeat_delay_ms     <= RST_REPEAT_DELAY;
            cfg_reg.repeat_rate_ms      <= RST_REPEAT_RATE;
            cfg_reg.handler_mask        <= RST_HANDLER_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/tpd_lane.sv @@
// One pad lane: debounce, press/release detection, hold and auto-repeat timing.
// Depends on tpd_pkg for the configuration, handler and result structs.
module tpd_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          first,
    input  logic                          raw,
    input  logic [tpd_pkg::TIME_W-1:0]    now,
    input  tpd_pkg::cfg_t                 cfg,
    input  tpd_pkg::hnd_t                 hnd,
    output tpd_pkg::lane_res_t            res
);
    import tpd_pkg::*;

    logic              prev_raw_reg, prev_raw_next;
    logic              deb_reg, deb_next;
    logic              hold_done_reg, hold_done_next;
    logic              repeat_on_reg, repeat_on_next;
    logic              pedge_reg, pedge_next;
    logic              redge_reg, redge_next;
    logic [TIME_W-1:0] rct_reg, rct_next;
    logic [TIME_W-1:0] pst_reg, pst_next;
    logic [TIME_W-1:0] lrt_reg, lrt_next;

    logic              raw_chg;
    logic [TIME_W-1:0] stable_dt;
    logic [TIME_W-1:0] held_dt;
    logic [TIME_W-1:0] rep_dt;
    logic [MS_W-1:0]   need;
    logic              pressed;
    logic              rise;
    logic              fall;
    logic              stay;
    logic              hold_fire;
    logic              rep_ok;
    logic              rep_first;
    logic              rep_next;
    logic              rel_fire;

    // Time differences, all modulo 2^32
    assign raw_chg   = raw != prev_raw_reg;
    assign stable_dt = raw_chg ? '0 : (now - rct_reg);
    assign held_dt   = now - pst_reg;
    assign rep_dt    = now - lrt_reg;
    assign need      = raw ? cfg.press_debounce_ms : cfg.release_debounce_ms;

    // Debounced level after this item
    always_comb
    begin
        pressed = deb_reg;
        if ((raw != deb_reg) && (stable_dt >= {{(TIME_W-MS_W){1'b0}}, need}))
        begin
            pressed = raw;
        end
    end

    // Event decisions
    assign rise      = pressed && !deb_reg;
    assign fall      = !pressed && deb_reg;
    assign stay      = pressed && deb_reg;
    assign hold_fire = stay && !hold_done_reg && hnd.hold && (cfg.hold_ms != '0) &&
                       (held_dt >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_ms});
    assign rel_fire  = fall && !hold_done_reg && hnd.release_en &&
                       (held_dt >= {{(TIME_W-MS_W){1'b0}}, cfg.min_action_ms});
    assign rep_ok    = stay && hnd.repeat_en && (cfg.repeat_delay_ms != '0) &&
                       (cfg.repeat_rate_ms != '0) &&
                       (held_dt >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_delay_ms});
    assign rep_first = rep_ok && !repeat_on_reg;
    assign rep_next  = rep_ok && repeat_on_reg &&
                       (rep_dt >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_rate_ms});

    // Next state of the lane
    always_comb
    begin
        prev_raw_next  = prev_raw_reg;
        deb_next       = deb_reg;
        hold_done_next = hold_done_reg;
        repeat_on_next = repeat_on_reg;
        pedge_next     = pedge_reg;
        redge_next     = redge_reg;
        rct_next       = rct_reg;
        pst_next       = pst_reg;
        lrt_next       = lrt_reg;
        if (step && first)
        begin
            // Prime only: latch the level and its time, clear edges
            prev_raw_next = raw;
            rct_next      = now;
            deb_next      = 1'b0;
            pedge_next    = 1'b0;
            redge_next    = 1'b0;
        end
        else if (step)
        begin
            prev_raw_next = raw;
            if (raw_chg)
            begin
                rct_next = now;
            end
            deb_next = pressed;
            if (rise)
            begin
                pst_next       = now;
                hold_done_next = 1'b0;
                repeat_on_next = 1'b0;
                lrt_next       = '0;
                pedge_next     = 1'b1;
                redge_next     = 1'b0;
            end
            else if (fall)
            begin
                redge_next     = 1'b1;
                pedge_next     = 1'b0;
                repeat_on_next = 1'b0;
            end
            else if (hold_fire)
            begin
                hold_done_next = 1'b1;
            end
            if (rep_first || rep_next)
            begin
                repeat_on_next = 1'b1;
                lrt_next       = now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= 1'b0;
            deb_reg       <= 1'b0;
            hold_done_reg <= 1'b0;
            repeat_on_reg <= 1'b0;
            pedge_reg     <= 1'b0;
            redge_reg     <= 1'b0;
            rct_reg       <= '0;
            pst_reg       <= '0;
            lrt_reg       <= '0;
        end
        else
        begin
            prev_raw_reg  <= prev_raw_next;
            deb_reg       <= deb_next;
            hold_done_reg <= hold_done_next;
            repeat_on_reg <= repeat_on_next;
            pedge_reg     <= pedge_next;
            redge_reg     <= redge_next;
            rct_reg       <= rct_next;
            pst_reg       <= pst_next;
            lrt_reg       <= lrt_next;
        end
    end

    // Report the lane result; the priming item reports nothing
    always_comb
    begin
        res = '0;
        if (!first)
        begin
            res.pressed      = pressed;
            res.ev_press     = rise && hnd.press;
            res.ev_release   = rel_fire;
            res.ev_hold      = hold_fire;
            res.ev_repeat    = rep_first || rep_next;
            res.press_edge   = pedge_next;
            res.release_edge = redge_next;
        end
    end

    // A fired hold is remembered until the next press
    a_hold_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !first && hold_fire) |=> hold_done_reg)
        else $error("hold event not latched");

    // Press and release edge flags exclude each other
    a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pedge_reg && redge_reg))
        else $error("press and release edge flags both set");

    // The debounced level moves only when an item is taken
    a_deb_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(deb_reg))
        else $error("debounced level changed without an item");

    // A release action never follows a fired hold in the same press
    a_rel_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.ev_release) |-> !hold_done_reg)
        else $error("release action after hold");

endmodule

@@ rtl/core/tpd_merge.sv @@
// Merge stage: gathers the lane results into one item and holds it in the
// output register until it is taken. Depends on tpd_pkg for the lane struct.
module tpd_merge #(
    parameter int PADS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  tpd_pkg::lane_res_t                 lane_res [PADS],
    output logic                               s_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import tpd_pkg::*;

    logic [MAX_PADS-1:0]   pressed_mask;
    logic [MAX_PADS-1:0]   press_events;
    logic [MAX_PADS-1:0]   release_actions;
    logic [MAX_PADS-1:0]   hold_events;
    logic [MAX_PADS-1:0]   repeat_events;
    logic [MAX_PADS-1:0]   press_edge_flags;
    logic [MAX_PADS-1:0]   release_edge_flags;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic                  valid_reg, valid_next;

    // Gather one bit per lane into each mask; pads beyond PADS stay zero
    always_comb
    begin
        pressed_mask       = '0;
        press_events       = '0;
        release_actions    = '0;
        hold_events        = '0;
        repeat_events      = '0;
        press_edge_flags   = '0;
        release_edge_flags = '0;
        for (int i = 0; i < PADS; i++)
        begin
            pressed_mask[i]       = lane_res[i].pressed;
            press_events[i]       = lane_res[i].ev_press;
            release_actions[i]    = lane_res[i].ev_release;
            hold_events[i]        = lane_res[i].ev_hold;
            repeat_events[i]      = lane_res[i].ev_repeat;
            press_edge_flags[i]   = lane_res[i].press_edge;
            release_edge_flags[i] = lane_res[i].release_edge;
        end
    end

    // Output register: load on a taken item, drop when the sink takes it
    assign s_ready = !valid_reg || m_tready;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (load)
        begin
            data_next  = {release_edge_flags, press_edge_flags, repeat_events,
                          hold_events, release_actions, press_events, pressed_mask};
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // An item is loaded only when the register is free or being emptied
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !load)
        else $error("output item overwritten while stalled");

    // A stalled item stays put
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled output item changed");

    // A loaded item is presented on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded item not presented");

endmodule

@@ rtl/core/touch_pad_debounce_hold_repeat_unit.sv @@
// Top level of the touch pad debounce, hold and auto-repeat unit.
// Depends on tpd_pkg, tpd_cfg, tpd_lane and tpd_merge.
//
//  Channel  Direction  Signals                          Payload
//  -------  ---------  -------------------------------  ------------------------------
//  s        in         s_tvalid s_tready s_tdata[39:0]  raw_status, now_ms
//  m        out        m_tvalid m_tready m_tdata[55:0]  seven 8-bit pad masks
//  cfg      in         cfg_we cfg_addr cfg_wdata        one register write per cycle
//
// All pad lanes evaluate each item in parallel and the merged result is
// in the output register on the next cycle.
// A new item is taken every cycle while the output register is empty or
// being drained; a stalled sink holds the result and stops input only then.
// Reset clears all pad state and loads register defaults; the first item
// after reset only primes the debounce timers and reports all zeros.
module touch_pad_debounce_hold_repeat_unit #(
    parameter int PADS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tpd_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] raw_status, [39:8] now_ms
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [7:0] pressed_mask,
                                                          // [15:8] press_events,
                                                          // [23:16] release_actions,
                                                          // [31:24] hold_events,
                                                          // [39:32] repeat_events,
                                                          // [47:40] press_edge_flags,
                                                          // [55:48] release_edge_flags
    input  logic                               cfg_we,
    input  logic [tpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tpd_pkg::*;

    cfg_t                cfg;
    logic                step;
    logic                first_reg;
    logic                first_next;
    logic [MAX_PADS-1:0] status;
    logic [TIME_W-1:0]   now;
    lane_res_t           lane_res [PADS];

    tpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Take an item and mask the raw status by the enabled pads
    assign step   = s_tvalid && s_tready;
    assign status = s_tdata[7:0] & cfg.enabled_inputs;
    assign now    = s_tdata[IN_DATA_W-1:8];

    // Clear the priming flag after the first item
    assign first_next = step ? 1'b0 : first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

    // One lane per pad
    for (genvar i = 0; i < PADS; i++)
    begin : g_lane
        hnd_t hnd;

        assign hnd.press      = cfg.handler_mask[i];
        assign hnd.release_en = cfg.handler_mask[MAX_PADS + i];
        assign hnd.hold       = cfg.handler_mask[2*MAX_PADS + i];
        assign hnd.repeat_en  = cfg.handler_mask[3*MAX_PADS + i];

        tpd_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .first (first_reg),
            .raw   (status[i]),
            .now   (now),
            .cfg   (cfg),
            .hnd   (hnd),
            .res   (lane_res[i])
        );
    end

    tpd_merge #(
        .PADS (PADS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .lane_res (lane_res),
        .s_ready  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
